### src/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

  // Element format.
  localparam int ELEMENT_WIDTH = 32;
  localparam int FRACTION_BITS = 16;

  // Number of matrix elements, which is also the number of divider lanes.
  localparam int Lanes = 9;

  // Exact widths of the intermediate values.
  localparam int ProdW = 2 * ELEMENT_WIDTH;
  localparam int CofW  = 2 * ELEMENT_WIDTH + 1;
  localparam int DetW  = 3 * ELEMENT_WIDTH + 3;

  // The quotient is |cof| * 2^(2F) / |det|. It is compared against 2^W first,
  // so the divisor is scaled by 2^W. The common power of two is dropped.
  localparam int ShiftS = (2 * FRACTION_BITS < ELEMENT_WIDTH) ? 2 * FRACTION_BITS
                                                               : ELEMENT_WIDTH;
  localparam int NumShift = 2 * FRACTION_BITS - ShiftS;
  localparam int DenShift = ELEMENT_WIDTH - ShiftS;
  localparam int NumW     = CofW + NumShift;
  localparam int DenW     = DetW + DenShift;
  localparam int RemW     = ((NumW > DenW) ? NumW : DenW) + 1;

  // One quotient bit per divider cell; the top bit flags an out of range result.
  localparam int QW = ELEMENT_WIDTH + 1;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } mat_t;

  typedef struct packed {
    elem_t inv00;
    elem_t inv01;
    elem_t inv02;
    elem_t inv10;
    elem_t inv11;
    elem_t inv12;
    elem_t inv20;
    elem_t inv21;
    elem_t inv22;
    logic  singular;
    logic  overflow;
  } inv_t;

  // Working set handed from one divider cell to the next.
  typedef struct packed {
    logic [Lanes-1:0][RemW-1:0] rem;
    logic [Lanes-1:0][QW-1:0]   q;
    logic [Lanes-1:0]           neg;
    logic [DenW-1:0]            den;
    logic                       singular;
  } div_t;

endpackage
`default_nettype wire

### src/mi3_mat_if.sv
`default_nettype none
interface mi3_mat_if import mi3_pkg::*; ();
  logic valid;
  logic ready;
  mat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/mi3_inv_if.sv
`default_nettype none
interface mi3_inv_if import mi3_pkg::*; ();
  logic valid;
  logic ready;
  inv_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/mi3_front.sv
`default_nettype none
module mi3_front import mi3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire mat_t in_data,
  output logic      out_valid,
  output div_t      out_data
);

  // Cofactor c = m[A]*m[B] - m[X]*m[Y], row-major element indexes.
  localparam int unsigned IdxA [Lanes] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned IdxB [Lanes] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned IdxX [Lanes] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned IdxY [Lanes] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  elem_t m [Lanes];

  logic [4:0] valid;

  logic signed [ProdW-1:0] pa [Lanes];
  logic signed [ProdW-1:0] ps [Lanes];
  elem_t                   m1 [3];

  logic signed [CofW-1:0]  cof2 [Lanes];
  elem_t                   m2 [3];

  logic signed [CofW-1:0]  cof3 [Lanes];
  logic signed [CofW:0]    plo [3];
  logic signed [CofW:0]    phi [3];

  logic signed [CofW-1:0]  cof4 [Lanes];
  logic signed [DetW-1:0]  det;
  logic signed [DetW-1:0]  det_next;

  div_t                    div_next;

  assign m[0] = in_data.m00;
  assign m[1] = in_data.m01;
  assign m[2] = in_data.m02;
  assign m[3] = in_data.m10;
  assign m[4] = in_data.m11;
  assign m[5] = in_data.m12;
  assign m[6] = in_data.m20;
  assign m[7] = in_data.m21;
  assign m[8] = in_data.m22;

  // Valid bits of the five front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  assign out_valid = valid[4];

  // Stage 1: the eighteen element products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Lanes; i++) begin
        pa[i] <= $signed(m[IdxA[i]]) * $signed(m[IdxB[i]]);
        ps[i] <= $signed(m[IdxX[i]]) * $signed(m[IdxY[i]]);
      end
      for (int j = 0; j < 3; j++) begin
        m1[j] <= m[j];
      end
    end
  end

  // Stage 2: the nine cofactors, exact.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Lanes; i++) begin
        cof2[i] <= CofW'(pa[i]) - CofW'(ps[i]);
      end
      m2 <= m1;
    end
  end

  // Stage 3: row 0 times the first column of cofactors, split into two halves.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo[j] <= $signed(m2[j]) * $signed({1'b0, cof2[3*j][ELEMENT_WIDTH-1:0]});
        phi[j] <= $signed(m2[j]) * $signed(cof2[3*j][CofW-1:ELEMENT_WIDTH]);
      end
      cof3 <= cof2;
    end
  end

  // Stage 4: determinant.
  always_comb begin
    det_next = '0;
    for (int j = 0; j < 3; j++) begin
      det_next = det_next + (DetW'(phi[j]) <<< ELEMENT_WIDTH) + DetW'(plo[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det  <= det_next;
      cof4 <= cof3;
    end
  end

  // Stage 5: magnitudes and signs for the divider.
  always_comb begin
    logic [CofW-1:0] acof;
    logic [DetW-1:0] adet;
    adet = det[DetW-1] ? DetW'(-det) : DetW'(det);
    div_next.den      = DenW'(adet) << DenShift;
    div_next.singular = (det == '0);
    for (int i = 0; i < Lanes; i++) begin
      acof = cof4[i][CofW-1] ? CofW'(-cof4[i]) : CofW'(cof4[i]);
      div_next.rem[i] = RemW'(acof) << NumShift;
      div_next.q[i]   = '0;
      div_next.neg[i] = cof4[i][CofW-1] ^ det[DetW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= div_next;
    end
  end

endmodule
`default_nettype wire

### src/mi3_div_cell.sv
`default_nettype none
module mi3_div_cell import mi3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire div_t in_data,
  output logic      out_valid,
  output div_t      out_data
);

  div_t data_next;

  // One restoring step in every lane: compare, subtract, shift.
  always_comb begin
    logic [RemW:0]   diff;
    logic            qbit;
    logic [RemW-1:0] r;
    data_next = in_data;
    for (int i = 0; i < Lanes; i++) begin
      diff = {1'b0, in_data.rem[i]} - {1'b0, RemW'(in_data.den)};
      qbit = !diff[RemW];
      r    = qbit ? diff[RemW-1:0] : in_data.rem[i];
      data_next.rem[i] = {r[RemW-2:0], 1'b0};
      data_next.q[i]   = {in_data.q[i][QW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

### src/matrix_inverse_3x3.sv
// Pipeline: 5 front stages, ELEMENT_WIDTH+1 divider cells and one output stage.
// Throughput: one item per cycle while the output is not held; the divider cells each resolve one quotient bit.
// A held result stalls the whole pipeline, and input is taken again when it moves.
// Reset (synchronous, active high) clears the valid bits; data registers keep their contents.
`default_nettype none
module matrix_inverse_3x3 import mi3_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  mi3_mat_if.sink    mat,
  mi3_inv_if.source  inv
);

  logic advance;

  logic       chain_valid [QW+1];
  div_t       chain_data  [QW+1];

  logic       out_valid;
  inv_t       out_data;
  inv_t       res_next;
  elem_t      res [Lanes];
  logic       any_sat;

  // The pipeline moves whenever the output register is free or being emptied.
  assign advance   = !out_valid || inv.ready;
  assign mat.ready = advance;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (mat.valid),
    .in_data   (mat.data),
    .out_valid (chain_valid[0]),
    .out_data  (chain_data[0])
  );

  // Chain of divider cells, most significant quotient bit first.
  for (genvar k = 0; k < QW; k++) begin : g_cell
    mi3_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (chain_valid[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  // Saturation, sign and the singular case.
  always_comb begin
    logic [ELEMENT_WIDTH-1:0] mag;
    logic [ELEMENT_WIDTH-1:0] lim;
    logic                     sat;
    logic [ELEMENT_WIDTH-1:0] sel;
    any_sat = 1'b0;
    for (int i = 0; i < Lanes; i++) begin
      mag = chain_data[QW].q[i][ELEMENT_WIDTH-1:0];
      lim = chain_data[QW].neg[i] ? {1'b1, {(ELEMENT_WIDTH-1){1'b0}}}
                                  : {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
      sat = chain_data[QW].q[i][QW-1] || (mag > lim);
      sel = sat ? lim : mag;
      any_sat = any_sat | sat;
      if (chain_data[QW].singular) begin
        res[i] = '0;
      end else begin
        res[i] = chain_data[QW].neg[i] ? elem_t'(-sel) : elem_t'(sel);
      end
    end
    res_next.inv00    = res[0];
    res_next.inv01    = res[1];
    res_next.inv02    = res[2];
    res_next.inv10    = res[3];
    res_next.inv11    = res[4];
    res_next.inv12    = res[5];
    res_next.inv20    = res[6];
    res_next.inv21    = res[7];
    res_next.inv22    = res[8];
    res_next.singular = chain_data[QW].singular;
    res_next.overflow = any_sat && !chain_data[QW].singular;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end

  assign inv.valid = out_valid;
  assign inv.data  = out_data;

endmodule
`default_nettype wire
